>>> rtl/core/hms_pkg.sv
// Shared constants, types and entity tables for the markup stripper.
`timescale 1ns / 1ps

package hms_pkg;

    // Longest entity name, including the leading ampersand; also the prefix buffer depth.
    localparam int ENTITY_MAX_LEN = 6;
    localparam int ENT_COUNT      = 7;
    // Width of a prefix length or replay position (holds 0..ENTITY_MAX_LEN).
    localparam int LEN_W          = $clog2(ENTITY_MAX_LEN + 1);
    // Width of an index into the prefix buffer.
    localparam int IDX_W          = $clog2(ENTITY_MAX_LEN);
    // Columns of the entity name table and the index width into a row.
    localparam int NAME_COLS      = 8;
    localparam int NAME_IDX_W     = $clog2(NAME_COLS);
    // Width of the output length register and the emitted character count.
    localparam int MAX_LEN_W      = 17;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(4096);

    // Character codes that steer the parser.
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Entity names in match priority order, zero padded.
    localparam logic [7:0] ENT_NAME [ENT_COUNT][NAME_COLS] = '{
        '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00, 8'h00, 8'h00},  // &amp;
        '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00, 8'h00},  // &lt;
        '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00, 8'h00},  // &gt;
        '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b, 8'h00, 8'h00},  // &quot;
        '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b, 8'h00, 8'h00},  // &apos;
        '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3b, 8'h00, 8'h00, 8'h00},  // &#39;
        '{8'h26, 8'h6e, 8'h62, 8'h73, 8'h70, 8'h3b, 8'h00, 8'h00}   // &nbsp;
    };
    localparam logic [LEN_W-1:0] ENT_LEN [ENT_COUNT] = '{
        LEN_W'(5), LEN_W'(4), LEN_W'(4), LEN_W'(6), LEN_W'(6), LEN_W'(5), LEN_W'(6)
    };
    localparam logic [7:0] ENT_VAL [ENT_COUNT] = '{
        8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h27, 8'h20
    };

    // Parser mode.
    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_TAG,
        MODE_ENTITY
    } mode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PARSE,
        S_EMIT,
        S_REPLAY,
        S_FINISH
    } state_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;     // input request may be taken
        logic load;         // latch the accepted input request
        logic parse;        // apply the parse step for the held byte
        logic emit_en;      // run one emit step
        logic from_prefix;  // emit step takes its character from the prefix buffer
        logic replay_end;   // prefix replay finished, return to text mode
        logic flush;        // close the byte: push held result, clear on end of text
    } cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic parse_emit;   // parse step leaves a character to emit
        logic parse_replay; // entity prefix failed and must be replayed
        logic emit_done;    // current emit step is complete
        logic replay_done;  // every buffered prefix character has been replayed
        logic in_entity;    // parser is collecting an entity
        logic end_flag;     // held byte is the last one of the text
        logic out_free;     // output register can take a result this cycle
    } status_t;

endpackage

>>> rtl/core/hms_if.sv
// Valid/ready stream interfaces for the input bytes and the output characters.
`timescale 1ns / 1ps

interface hms_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface hms_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       last;

    modport source (output valid, output out_char, output char_valid, output last,
                    input ready);
    modport sink (input valid, input out_char, input char_valid, input last,
                  output ready);
endinterface

>>> rtl/core/hms_ctrl.sv
// Sequencer that steps each input byte through parse, emit, replay and finish.
`timescale 1ns / 1ps

module hms_ctrl
    import hms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    // After a replay: 1 returns to parse the held byte, 0 returns to finish.
    logic   ret_parse_reg;
    logic   ret_parse_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_parse_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_parse_reg <= ret_parse_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        ret_parse_next = ret_parse_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PARSE;
                end
            end
            S_PARSE:
            begin
                cmd.parse = 1'b1;
                if (status.parse_replay)
                begin
                    ret_parse_next = 1'b1;
                    state_next     = S_REPLAY;
                end
                else if (status.parse_emit)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_EMIT:
            begin
                cmd.emit_en = 1'b1;
                if (status.emit_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_REPLAY:
            begin
                if (status.replay_done)
                begin
                    cmd.replay_end = 1'b1;
                    state_next     = ret_parse_reg ? S_PARSE : S_FINISH;
                end
                else
                begin
                    cmd.emit_en     = 1'b1;
                    cmd.from_prefix = 1'b1;
                end
            end
            S_FINISH:
            begin
                // An entity still open at the end of the text is replayed first.
                if (status.end_flag && status.in_entity)
                begin
                    ret_parse_next = 1'b0;
                    state_next     = S_REPLAY;
                end
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/hms_datapath.sv
// Parser state, entity prefix buffer, emit unit, result hold stage and output register.
`timescale 1ns / 1ps

module hms_datapath
    import hms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic [7:0]           text_byte,
    input  logic                 text_end,
    input  logic                 cfg_we,
    input  logic [MAX_LEN_W-1:0] cfg_wdata,
    input  logic                 out_ready,
    output status_t              status,
    output logic                 out_valid,
    output logic [7:0]           out_char,
    output logic                 char_valid,
    output logic                 last
);

    // Registers.
    mode_t                mode_reg, mode_next;
    logic                 pending_reg, pending_next;
    logic [MAX_LEN_W-1:0] count_reg, count_next;
    logic                 full_reg, full_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     idx_reg, idx_next;
    logic [MAX_LEN_W-1:0] max_len_reg, max_len_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 end_reg, end_next;
    logic [7:0]           src_reg, src_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [7:0]           hold_char_reg, hold_char_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_char_reg, out_char_next;
    logic                 out_cval_reg, out_cval_next;
    logic                 out_last_reg, out_last_next;
    logic [7:0]           prefix_reg [ENTITY_MAX_LEN];

    // Prefix buffer write port.
    logic                 prefix_we;
    logic [IDX_W-1:0]     prefix_widx;

    // Entity match results.
    logic                 ent_hit;
    logic                 ent_done;
    logic [7:0]           ent_val;

    // Parse decode.
    logic                 is_ws;
    logic                 parse_emit;
    logic                 parse_replay;

    // Emit unit.
    logic [7:0]           emit_src;
    logic                 no_room;
    logic                 out_free;
    logic                 can_push;
    logic                 produce;
    logic [7:0]           prod_char;
    logic                 emit_done;
    logic                 push_ok;

    // Match the held byte against every entity that extends the buffered prefix.
    always_comb
    begin
        logic same;
        ent_hit  = 1'b0;
        ent_done = 1'b0;
        ent_val  = CH_NUL;
        // Walk from the back so the first entity in the table wins.
        for (int k = ENT_COUNT - 1; k >= 0; k--)
        begin
            same = (ENT_LEN[k] > len_reg);
            for (int i = 0; i < ENTITY_MAX_LEN; i++)
            begin
                if ((LEN_W'(i) < len_reg) && (prefix_reg[i] != ENT_NAME[k][i]))
                begin
                    same = 1'b0;
                end
            end
            if (ENT_NAME[k][NAME_IDX_W'(len_reg)] != byte_reg)
            begin
                same = 1'b0;
            end
            if (same)
            begin
                ent_hit  = 1'b1;
                ent_done = (ENT_LEN[k] == len_reg + LEN_W'(1));
                ent_val  = ENT_VAL[k];
            end
        end
        if ((len_reg == '0) || (len_reg >= LEN_W'(ENTITY_MAX_LEN)))
        begin
            ent_hit = 1'b0;
        end
    end

    assign is_ws = byte_reg inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};

    // Decide whether the parse step ends in an emit or a replay.
    always_comb
    begin
        parse_emit   = 1'b0;
        parse_replay = 1'b0;
        case (mode_reg)
            MODE_TAG:
            begin
                parse_emit = 1'b0;
            end
            MODE_ENTITY:
            begin
                if (!ent_hit)
                begin
                    parse_replay = 1'b1;
                end
                else if (ent_done && (ent_val != CH_SPACE))
                begin
                    parse_emit = 1'b1;
                end
            end
            default:
            begin
                parse_emit = !(is_ws || (byte_reg == CH_LT) || (byte_reg == CH_AMP));
            end
        endcase
    end

    // Emit unit: a pending space goes out first, then the character itself.
    assign emit_src = cmd.from_prefix ? prefix_reg[idx_reg[IDX_W-1:0]] : src_reg;
    assign no_room  = ({1'b0, count_reg} + (MAX_LEN_W + 1)'(1)) >= {1'b0, max_len_reg};
    assign out_free = !out_valid_reg || out_ready;
    assign can_push = !hold_valid_reg || out_free;

    always_comb
    begin
        produce   = 1'b0;
        prod_char = emit_src;
        emit_done = 1'b0;
        if (full_reg || no_room)
        begin
            emit_done = 1'b1;
        end
        else if (pending_reg)
        begin
            produce   = 1'b1;
            prod_char = CH_SPACE;
        end
        else
        begin
            produce   = 1'b1;
            emit_done = can_push;
        end
    end

    assign push_ok = cmd.emit_en && produce && can_push;

    // Next values of the datapath registers.
    always_comb
    begin
        mode_next       = mode_reg;
        pending_next    = pending_reg;
        count_next      = count_reg;
        full_next       = full_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        max_len_next    = max_len_reg;
        byte_next       = byte_reg;
        end_next        = end_reg;
        src_next        = src_reg;
        hold_valid_next = hold_valid_reg;
        hold_char_next  = hold_char_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_char_next   = out_char_reg;
        out_cval_next   = out_cval_reg;
        out_last_next   = out_last_reg;
        prefix_we       = 1'b0;
        prefix_widx     = IDX_W'(len_reg);

        // Latch an accepted input request.
        if (cmd.load)
        begin
            byte_next = text_byte;
            end_next  = text_end;
        end

        // Parse step; a failed entity leaves the state to the replay.
        if (cmd.parse && !parse_replay)
        begin
            case (mode_reg)
                MODE_TAG:
                begin
                    if (byte_reg == CH_GT)
                    begin
                        mode_next = MODE_TEXT;
                    end
                end
                MODE_ENTITY:
                begin
                    if (ent_done)
                    begin
                        len_next  = '0;
                        mode_next = MODE_TEXT;
                        if (ent_val == CH_SPACE)
                        begin
                            pending_next = pending_reg || (count_reg != '0);
                        end
                        else
                        begin
                            src_next = ent_val;
                        end
                    end
                    else
                    begin
                        prefix_we = 1'b1;
                        len_next  = len_reg + LEN_W'(1);
                    end
                end
                default:
                begin
                    if (byte_reg == CH_LT)
                    begin
                        pending_next = pending_reg || (count_reg != '0);
                        mode_next    = MODE_TAG;
                    end
                    else if (byte_reg == CH_AMP)
                    begin
                        prefix_we   = 1'b1;
                        prefix_widx = '0;
                        len_next    = LEN_W'(1);
                        mode_next   = MODE_ENTITY;
                    end
                    else if (is_ws)
                    begin
                        pending_next = pending_reg || (count_reg != '0);
                    end
                    else
                    begin
                        src_next = byte_reg;
                    end
                end
            endcase
        end

        // Emit step: count the character and move it into the hold stage.
        if (cmd.emit_en)
        begin
            if (!full_reg && no_room)
            begin
                full_next = 1'b1;
            end
            if (push_ok)
            begin
                count_next   = count_reg + MAX_LEN_W'(1);
                pending_next = 1'b0;
                if (hold_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = hold_char_reg;
                    out_cval_next  = 1'b1;
                    out_last_next  = 1'b0;
                end
                hold_valid_next = 1'b1;
                hold_char_next  = prod_char;
            end
            if (emit_done && cmd.from_prefix)
            begin
                idx_next = idx_reg + LEN_W'(1);
            end
        end

        // Replay finished.
        if (cmd.replay_end)
        begin
            len_next  = '0;
            idx_next  = '0;
            mode_next = MODE_TEXT;
        end

        // Close the byte: the held result goes out, marked last at end of text.
        if (cmd.flush)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_char_next   = hold_char_reg;
                out_cval_next   = 1'b1;
                out_last_next   = end_reg;
                hold_valid_next = 1'b0;
            end
            else if (end_reg)
            begin
                out_valid_next = 1'b1;
                out_char_next  = CH_NUL;
                out_cval_next  = 1'b0;
                out_last_next  = 1'b1;
            end
            if (end_reg)
            begin
                mode_next    = MODE_TEXT;
                pending_next = 1'b0;
                count_next   = '0;
                full_next    = 1'b0;
                len_next     = '0;
                idx_next     = '0;
            end
        end

        // Configuration write.
        if (cfg_we)
        begin
            max_len_next = cfg_wdata;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_TEXT;
            pending_reg    <= 1'b0;
            count_reg      <= '0;
            full_reg       <= 1'b0;
            len_reg        <= '0;
            idx_reg        <= '0;
            max_len_reg    <= MAX_LEN_RESET;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            pending_reg    <= pending_next;
            count_reg      <= count_next;
            full_reg       <= full_next;
            len_reg        <= len_next;
            idx_reg        <= idx_next;
            max_len_reg    <= max_len_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        end_reg       <= end_next;
        src_reg       <= src_next;
        hold_char_reg <= hold_char_next;
        out_char_reg  <= out_char_next;
        out_cval_reg  <= out_cval_next;
        out_last_reg  <= out_last_next;
    end

    // Entity prefix buffer.
    always_ff @(posedge clk)
    begin
        if (prefix_we)
        begin
            prefix_reg[prefix_widx] <= byte_reg;
        end
    end

    // Status back to the sequencer.
    assign status.parse_emit   = parse_emit;
    assign status.parse_replay = parse_replay;
    assign status.emit_done    = emit_done;
    assign status.replay_done  = (idx_reg == len_reg);
    assign status.in_entity    = (mode_reg == MODE_ENTITY);
    assign status.end_flag     = end_reg;
    assign status.out_free     = out_free;

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign char_valid = out_cval_reg;
    assign last       = out_last_reg;

endmodule

>>> rtl/core/html_markup_stripper.sv
// Top level of the markup stripper: sequencer and datapath joined by command and status.
//
//   Channel     Dir  Handshake         Payload
//   text_in     in   valid / ready     in_byte[7:0], end_of_text
//   text_out    out  valid / ready     out_char[7:0], char_valid, last
//   cfg         in   cfg_we            cfg_wdata[16:0] (max_out_len)
//
// One request is taken at a time. A tag, whitespace or entity-collecting byte passes the
// parse and finish states, a byte that emits a character passes emit as well, and a
// pending space adds an emit step. A failed entity prefix replays each buffered character,
// ends the replay and parses the byte again. A prefix left open at the end of the text
// is likewise replayed before the finish.
// Results pass a one-entry hold stage so the final one of a text can be marked last.
// A stalled output holds the emit unit and the input; reset is asynchronous and clears
// all control state, with max_out_len returning to 4096.
`timescale 1ns / 1ps

module html_markup_stripper
    import hms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    hms_in_if.sink               text_in,
    hms_out_if.source            text_out,
    input  logic                 cfg_we,
    input  logic [MAX_LEN_W-1:0] cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    hms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text_in.valid),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    hms_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .text_byte  (text_in.in_byte),
        .text_end   (text_in.end_of_text),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_ready  (text_out.ready),
        .status     (status),
        .out_valid  (text_out.valid),
        .out_char   (text_out.out_char),
        .char_valid (text_out.char_valid),
        .last       (text_out.last)
    );

    assign text_in.ready = cmd.in_ready;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench that streams text through the markup stripper and predicts its output.
`timescale 1ns / 1ps

module tb_top;
    import hms_pkg::*;

    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int RX_HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES    = 16;
    localparam int RANDOM_ITEMS     = 310;
    localparam int MAX_REPORTS      = 10;
    localparam int CHARS_PER_BYTE   = 8;
    localparam int N_ENTITIES       = 7;
    localparam int RESET_CYCLES     = 12;
    localparam logic [MAX_LEN_W-1:0] DEFAULT_MAX_LEN = 17'd4096;
    localparam logic [MAX_LEN_W-1:0] WIDEST_MAX_LEN  = 17'h10000;

    // One character of plain text as it leaves the block.
    typedef struct {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } plain_char_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [MAX_LEN_W-1:0] cfg_wdata;

    hms_in_if  text_in_ch ();
    hms_out_if text_out_ch ();

    html_markup_stripper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in_ch),
        .text_out  (text_out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state: parser mode, whitespace and length tracking, buffered entity prefix.
    mode_t                ps_mode;
    logic                 ps_space_due;
    int unsigned          ps_emitted;
    logic                 ps_full;
    logic [7:0]           ps_held [ENTITY_MAX_LEN];
    int unsigned          ps_held_len;
    logic [MAX_LEN_W-1:0] ps_max_len;

    // Characters produced by the current request, and all characters still to arrive.
    plain_char_t byte_chars [$];
    plain_char_t pending_chars [$];

    // Entity spellings and the characters they decode to.
    string      ent_spell [N_ENTITIES] = '{"&amp;", "&lt;", "&gt;", "&quot;", "&apos;",
                                           "&#39;", "&nbsp;"};
    logic [7:0] ent_glyph [N_ENTITIES] = '{"&", "<", ">", "\"", "'", "'", " "};
    logic [7:0] blank_set [4];

    // Shared test controls.
    logic       no_gaps;
    logic       rx_hold_req;
    int         mismatches;
    int         quiet_cycles;
    int         items_sent;
    int         ent_turn;
    logic [7:0] draft [$];

    // Free-running clock, 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void add_char(logic [7:0] c, logic has_char);
        plain_char_t r;
        if (byte_chars.size() < CHARS_PER_BYTE)
        begin
            r.ch       = c;
            r.has_char = has_char;
            r.last     = 1'b0;
            byte_chars.push_back(r);
        end
    endfunction

    // Checks for room in the output buffer; the first refusal latches full for the text.
    function automatic logic room_for_char();
        if (ps_full)
            return 1'b0;
        if (ps_emitted + 1 >= ps_max_len)
        begin
            ps_full = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Emits a visible character, preceded by a collapsed space when one is due.
    function automatic void put_char(logic [7:0] c);
        if (ps_space_due)
        begin
            if (!room_for_char())
                return;
            add_char(CH_SPACE, 1'b1);
            ps_emitted++;
            ps_space_due = 1'b0;
        end
        if (!room_for_char())
            return;
        add_char(c, 1'b1);
        ps_emitted++;
    endfunction

    // A space break only counts once something has been emitted.
    function automatic void mark_break();
        if (ps_emitted > 0)
            ps_space_due = 1'b1;
    endfunction

    function automatic void text_char(logic [7:0] c);
        if (c == CH_LT)
        begin
            mark_break();
            ps_mode = MODE_TAG;
        end
        else if (c == CH_AMP)
        begin
            ps_held[0]  = c;
            ps_held_len = 1;
            ps_mode     = MODE_ENTITY;
        end
        else if (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})
        begin
            mark_break();
        end
        else
        begin
            put_char(c);
        end
    endfunction

    // Gives back a failed entity prefix as literal text.
    function automatic void replay_held();
        int unsigned n;
        n = (ps_held_len > ENTITY_MAX_LEN) ? ENTITY_MAX_LEN : ps_held_len;
        ps_held_len = 0;
        ps_mode     = MODE_TEXT;
        for (int i = 0; i < n; i++)
            put_char(ps_held[i]);
    endfunction

    // Extends, completes or abandons the entity being collected.
    function automatic void entity_char(logic [7:0] c);
        int unsigned plen;
        logic        same;
        plen = ps_held_len;
        if (plen > 0 && plen < ENTITY_MAX_LEN)
        begin
            for (int k = 0; k < N_ENTITIES; k++)
            begin
                if (ent_spell[k].len() <= plen)
                    continue;
                same = 1'b1;
                for (int j = 0; j < plen; j++)
                    if (8'(ent_spell[k][j]) != ps_held[j])
                        same = 1'b0;
                if (!same || 8'(ent_spell[k][plen]) != c)
                    continue;
                if (ent_spell[k].len() == plen + 1)
                begin
                    ps_held_len = 0;
                    ps_mode     = MODE_TEXT;
                    if (ent_glyph[k] == CH_SPACE)
                        mark_break();
                    else
                        put_char(ent_glyph[k]);
                end
                else
                begin
                    ps_held[plen] = c;
                    ps_held_len   = plen + 1;
                end
                return;
            end
        end
        replay_held();
        text_char(c);
    endfunction

    function automatic void clear_text_state();
        ps_mode      = MODE_TEXT;
        ps_space_due = 1'b0;
        ps_emitted   = 0;
        ps_full      = 1'b0;
        ps_held_len  = 0;
        foreach (ps_held[i])
            ps_held[i] = 8'h00;
    endfunction

    // Works out every character one accepted request produces and queues them.
    function automatic void predict_plain_text(logic [7:0] c, logic eot);
        byte_chars.delete();
        case (ps_mode)
            MODE_TAG:
                if (c == CH_GT)
                    ps_mode = MODE_TEXT;
            MODE_ENTITY:
                entity_char(c);
            default:
                text_char(c);
        endcase
        if (eot)
        begin
            if (ps_mode == MODE_ENTITY)
                replay_held();
            if (byte_chars.size() == 0)
                add_char(CH_NUL, 1'b0);
            byte_chars[byte_chars.size() - 1].last = 1'b1;
            clear_text_state();
        end
        foreach (byte_chars[i])
            pending_chars.push_back(byte_chars[i]);
    endfunction

    // Sends one byte request after a random gap and predicts it once accepted.
    task automatic send_char(input logic [7:0] c, input logic eot);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            text_in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_in_ch.valid       <= 1'b1;
        text_in_ch.in_byte     <= c;
        text_in_ch.end_of_text <= eot;
        do @(posedge clk); while (!text_in_ch.ready);
        predict_plain_text(c, eot);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic close);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], close && (i == s.len() - 1));
    endtask

    // Stops offering requests and waits for the block to go quiet.
    task automatic wait_until_drained();
        text_in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [MAX_LEN_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ps_max_len = v;
        @(posedge clk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(8'h21, 8'h7e));
        while (c == CH_LT || c == CH_AMP);
        return c;
    endfunction

    function automatic logic [MAX_LEN_W-1:0] pick_max_len();
        case ($urandom_range(0, 5))
            0:       return 17'd1;
            1:       return 17'd2;
            2:       return MAX_LEN_W'($urandom_range(3, 24));
            3:       return WIDEST_MAX_LEN;
            4:       return MAX_LEN_W'($urandom_range(25, 300));
            default: return DEFAULT_MAX_LEN;
        endcase
    endfunction

    // Builds a text of words, whitespace, tags, entities, broken entities and noise.
    // Truncation to the target length can leave a tag or an entity open at the end.
    function automatic void draft_random_text(int target);
        int    n;
        int    k;
        string s;
        draft.delete();
        while (draft.size() < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n) draft.push_back(plain_byte());
                end
                3, 4:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) draft.push_back(blank_set[$urandom_range(0, 3)]);
                end
                5:
                begin
                    draft.push_back(CH_LT);
                    n = $urandom_range(0, 5);
                    repeat (n) draft.push_back(plain_byte());
                    draft.push_back(CH_GT);
                end
                6:
                begin
                    s = ent_spell[ent_turn % N_ENTITIES];
                    ent_turn++;
                    for (int i = 0; i < s.len(); i++)
                        draft.push_back(s[i]);
                end
                7:
                begin
                    k = $urandom_range(0, N_ENTITIES - 1);
                    s = ent_spell[k];
                    n = $urandom_range(1, s.len() - 1);
                    for (int i = 0; i < n; i++)
                        draft.push_back(s[i]);
                    draft.push_back(8'($urandom_range(1, 255)));
                end
                default:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) draft.push_back(8'($urandom_range(1, 255)));
                end
            endcase
        end
        while (draft.size() > target)
            void'(draft.pop_back());
    endfunction

    // Leading space, a tag before any text, a decoded entity and a prefix left open at the end.
    task automatic test_markup_basics();
        send_text(" <i>x&lt;y&q", 1'b1);
    endtask

    // A tag that never closes swallows the rest, leaving only the end marker.
    task automatic test_unclosed_tag();
        send_text("<ab", 1'b1);
    endtask

    // A zero byte and the top byte value pass through as ordinary characters.
    task automatic test_raw_bytes();
        send_char(CH_NUL, 1'b0);
        send_char(8'hff, 1'b1);
    endtask

    // Output limit: a full buffer stays full mid-text even after the limit is raised.
    task automatic test_output_limit();
        wait_until_drained();
        write_max_len(17'd3);
        send_text("abc", 1'b0);
        wait_until_drained();
        write_max_len(WIDEST_MAX_LEN);
        send_text("d", 1'b1);
        wait_until_drained();
        write_max_len(17'd1);
        send_text("z", 1'b1);
        wait_until_drained();
        write_max_len(DEFAULT_MAX_LEN);
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        rx_hold_req = 1'b1;
        no_gaps     = 1'b1;
        draft_random_text(40);
        foreach (draft[i])
            send_char(draft[i], i == draft.size() - 1);
        no_gaps = 1'b0;
        wait_until_drained();
    endtask

    // Random texts, with the limit changed between some of them.
    task automatic test_random_texts();
        int start;
        int texts;
        start = items_sent;
        texts = 0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if (texts % 4 == 3)
            begin
                wait_until_drained();
                write_max_len(pick_max_len());
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            draft_random_text($urandom_range(4, 30));
            foreach (draft[i])
                send_char(draft[i], i == draft.size() - 1);
            texts++;
        end
        no_gaps = 1'b0;
    endtask

    // Test sequence.
    initial
    begin : run_tests
        blank_set    = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
        no_gaps      = 1'b0;
        rx_hold_req  = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        items_sent   = 0;
        ent_turn     = 0;
        clear_text_state();
        ps_max_len   = DEFAULT_MAX_LEN;
        text_in_ch.valid       <= 1'b0;
        text_in_ch.in_byte     <= 8'h00;
        text_in_ch.end_of_text <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_wdata              <= '0;
        rst_n                  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_markup_basics();
        test_unclosed_tag();
        test_raw_bytes();
        test_output_limit();
        test_output_backpressure();
        test_random_texts();
        wait_until_drained();
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Receiver: random stall before each result, with an occasional long hold.
    initial
    begin : output_sink
        int stall;
        text_out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                text_out_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else
            begin
                stall = no_gaps ? 0 : $urandom_range(0, 10);
                if (stall > 0)
                begin
                    text_out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                text_out_ch.ready <= 1'b1;
                do @(posedge clk); while (!text_out_ch.valid);
            end
        end
    end

    // Compares each accepted result with the oldest predicted character.
    always @(posedge clk)
    begin : check_output
        plain_char_t want;
        if (text_out_ch.valid && text_out_ch.ready)
        begin
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: char %h valid %b last %b",
                             text_out_ch.out_char, text_out_ch.char_valid, text_out_ch.last);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (text_out_ch.out_char !== want.ch || text_out_ch.char_valid !== want.has_char
                    || text_out_ch.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected char %h valid %b last %b, got %h %b %b",
                                 want.ch, want.has_char, want.last, text_out_ch.out_char,
                                 text_out_ch.char_valid, text_out_ch.last);
                end
            end
        end
    end

    // Ends the run when no request moves on either side for too long.
    always @(posedge clk)
    begin : watchdog
        if ((text_in_ch.valid && text_in_ch.ready) || (text_out_ch.valid && text_out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

endmodule
